// ----- rtl/kglip_pkg.sv -----
// shared types and constants for the key group last-input-priority filter
package kglip_pkg;

    // default sizes
    localparam int NUM_KEYS_DEF   = 256;
    localparam int NUM_GROUPS_DEF = 'h10;

    // result kinds
    localparam logic [1:0] KIND_PASS        = 2'd0;
    localparam logic [1:0] KIND_SYNTH       = 2'd1;
    localparam logic [1:0] KIND_BIND_OK     = 2'd2;
    localparam logic [1:0] KIND_BIND_REJECT = 2'd3;

    // input class decided at the front
    typedef enum logic [1:0] {
        CLS_BIND,
        CLS_PASS,
        CLS_EVENT
    } t_cls;

    // queue word between front and back
    typedef struct packed {
        t_cls       cls;
        logic [7:0] key;
        logic       pressed;
        logic [3:0] gid;
        logic       in_range;
    } t_qent;

    // one result word
    typedef struct packed {
        logic [7:0] key;
        logic       pressed;
        logic [1:0] kind;
        logic       last;
    } t_res;

endpackage

// ----- rtl/kglip_in_if.sv -----
// input channel: key event or bind word
interface kglip_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] key_code;
    logic       key_pressed;
    logic       injected;
    logic [3:0] group_id;

    modport source (
        output valid, operation, key_code, key_pressed, injected, group_id,
        input  ready
    );
    modport sink (
        input  valid, operation, key_code, key_pressed, injected, group_id,
        output ready
    );
endinterface

// ----- rtl/kglip_out_if.sv -----
// output channel: reported key event or bind status word
interface kglip_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_key;
    logic       out_pressed;
    logic [1:0] kind;
    logic       last;

    modport source (
        output valid, out_key, out_pressed, kind, last,
        input  ready
    );
    modport sink (
        input  valid, out_key, out_pressed, kind, last,
        output ready
    );
endinterface

// ----- rtl/kglip_ram.sv -----
// generic single-port-write ram with registered read
module kglip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/kglip_fifo.sv -----
// small register fifo
module kglip_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

// ----- rtl/kglip_front.sv -----
// front end: takes input words, holds bypass, classifies into queue words
module kglip_front
    import kglip_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    kglip_in_if.sink   i_in_word,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_qent      o_q_data
);
    logic r_bypass;
    logic in_range;

    // bypass register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass <= 1'b0;
        end else if (i_cfg_we) begin
            r_bypass <= i_cfg_wdata;
        end
    end

    assign in_range        = ({1'b0, i_in_word.key_code} < 9'(NUM_KEYS));
    assign i_in_word.ready = !i_q_full;
    assign o_q_push        = i_in_word.valid && !i_q_full;

    // classify the word
    always_comb begin
        o_q_data.key      = i_in_word.key_code;
        o_q_data.pressed  = i_in_word.key_pressed;
        o_q_data.gid      = i_in_word.group_id;
        o_q_data.in_range = in_range;
        if (i_in_word.operation) begin
            o_q_data.cls = CLS_BIND;
        end else if (r_bypass || i_in_word.injected || !in_range) begin
            o_q_data.cls = CLS_PASS;
        end else begin
            o_q_data.cls = CLS_EVENT;
        end
    end
endmodule

// ----- rtl/kglip_back.sv -----
// back end: key and group state, read-modify-write, result generation
module kglip_back
    import kglip_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int NUM_GROUPS = NUM_GROUPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_qent i_q_data,
    output logic  o_q_pop,
    input  logic  i_res_full,
    output logic  o_res_push,
    output t_res  o_res
);
    localparam int KW = $clog2(NUM_KEYS);
    localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int EW = GW + 1;

    // per-key and per-group state
    logic [NUM_KEYS-1:0] r_bound;
    logic [7:0]          r_act  [NUM_GROUPS];
    logic [7:0]          r_prev [NUM_GROUPS];

    // execute slot, ram bypass, pending second result
    logic          r_b_valid;
    t_qent         r_b;
    logic          r_fwd;
    logic [EW-1:0] r_fwd_ent;
    logic          r_pend_valid;
    t_res          r_pend;

    logic [GW-1:0] mod_tab [16];
    logic [GW-1:0] grp_cur, gid_red;
    logic [EW-1:0] ent_rd, ent_cur, ent_wdata;
    logic          ent_we;
    logic [KW-1:0] b_kidx, q_kidx;
    logic          b_load, b_exec;
    logic          bound_b, held_b, bind_ok;
    logic [7:0]    act, prev;

    logic          res1_v, res2_v;
    t_res          res1, res2;
    logic          held_we, held_new;
    logic          act_we, prev_we;
    logic [7:0]    act_new, prev_new;

    // group number wrap table
    for (genvar i = 0; i < 16; i++) begin : g_mod
        assign mod_tab[i] = GW'(i % NUM_GROUPS);
    end

    assign b_kidx  = r_b.key[KW-1:0];
    assign q_kidx  = i_q_data.key[KW-1:0];
    assign b_exec  = r_b_valid && !r_pend_valid && !i_res_full;
    assign b_load  = i_q_valid && (!r_b_valid || b_exec);
    assign o_q_pop = b_load;

    // key entry: held flag over group number
    assign gid_red   = mod_tab[r_b.gid];
    assign ent_cur   = r_fwd ? r_fwd_ent : ent_rd;
    assign grp_cur   = ent_cur[GW-1:0];
    assign held_b    = ent_cur[GW];
    assign bound_b   = r_bound[b_kidx];
    assign act       = r_act[grp_cur];
    assign prev      = r_prev[grp_cur];
    assign bind_ok   = (r_b.cls == CLS_BIND) && r_b.in_range && !bound_b;
    assign ent_we    = b_exec && (bind_ok || held_we);
    assign ent_wdata = bind_ok ? {1'b0, gid_red} : {held_new, grp_cur};

    // per-key group number and held flag, undefined until bound; a bind writes both
    kglip_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_KEYS)
    ) u_grp_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (b_kidx),
        .i_wdata (ent_wdata),
        .i_re    (b_load),
        .i_raddr (q_kidx),
        .o_rdata (ent_rd)
    );

    // decide results and state changes for the word in the execute slot
    always_comb begin
        res1_v   = 1'b0;
        res2_v   = 1'b0;
        res1     = '{key: r_b.key, pressed: r_b.pressed, kind: KIND_PASS, last: 1'b1};
        res2     = '{key: 8'd0, pressed: 1'b0, kind: KIND_SYNTH, last: 1'b1};
        held_we  = 1'b0;
        held_new = 1'b0;
        act_we   = 1'b0;
        act_new  = act;
        prev_we  = 1'b0;
        prev_new = prev;
        case (r_b.cls)
            CLS_BIND: begin
                res1_v       = 1'b1;
                res1.pressed = 1'b0;
                res1.kind    = bind_ok ? KIND_BIND_OK : KIND_BIND_REJECT;
            end
            CLS_PASS: begin
                res1_v = 1'b1;
            end
            CLS_EVENT: begin
                if (!bound_b) begin
                    res1_v = 1'b1;
                end else if (r_b.pressed) begin
                    // new press takes over the group
                    if (!held_b) begin
                        held_we      = 1'b1;
                        held_new     = 1'b1;
                        res1_v       = 1'b1;
                        res1.kind    = KIND_SYNTH;
                        act_we       = 1'b1;
                        act_new      = r_b.key;
                        if (act != 8'd0 && act != r_b.key) begin
                            prev_we  = 1'b1;
                            prev_new = act;
                            res2_v   = 1'b1;
                            res2.key = act;
                        end
                    end
                end else begin
                    // release, with restore of the earlier key
                    if (!held_b) begin
                        if (prev == r_b.key) begin
                            prev_we  = 1'b1;
                            prev_new = 8'd0;
                        end
                    end else begin
                        held_we   = 1'b1;
                        held_new  = 1'b0;
                        res1_v    = 1'b1;
                        res1.kind = KIND_SYNTH;
                        prev_we   = 1'b1;
                        prev_new  = 8'd0;
                        if (act == r_b.key && prev != 8'd0) begin
                            act_we       = 1'b1;
                            act_new      = prev;
                            res2_v       = 1'b1;
                            res2.key     = prev;
                            res2.pressed = 1'b1;
                        end else if (act == r_b.key) begin
                            act_we  = 1'b1;
                            act_new = 8'd0;
                        end
                    end
                end
            end
            default: begin
                res1_v = 1'b0;
            end
        endcase
        res1.last = !res2_v;
    end

    assign o_res_push = r_pend_valid ? !i_res_full : (b_exec && res1_v);
    assign o_res      = r_pend_valid ? r_pend : res1;

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound      <= '0;
            r_b_valid    <= 1'b0;
            r_fwd        <= 1'b0;
            r_pend_valid <= 1'b0;
            for (int i = 0; i < NUM_GROUPS; i++) begin
                r_act[i]  <= 8'd0;
                r_prev[i] <= 8'd0;
            end
        end else begin
            if (b_exec) begin
                if (bind_ok) begin
                    r_bound[b_kidx] <= 1'b1;
                end
                if (act_we) begin
                    r_act[grp_cur] <= act_new;
                end
                if (prev_we) begin
                    r_prev[grp_cur] <= prev_new;
                end
                r_pend_valid <= res2_v;
            end else if (r_pend_valid && !i_res_full) begin
                r_pend_valid <= 1'b0;
            end
            if (b_load) begin
                r_b_valid <= 1'b1;
                r_fwd     <= ent_we && (q_kidx == b_kidx);
            end else if (b_exec) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b       <= i_q_data;
            r_fwd_ent <= ent_wdata;
        end
        if (b_exec) begin
            r_pend <= res2;
        end
    end
endmodule

// ----- rtl/key_group_last_input_priority.sv -----
// path: input word, command queue, execute slot, output queue, first result word
// throughput: one word per cycle; full output or a second result stalls it
// the back-end execute slot and its single result write per cycle set the rate
// reset: synchronous active-low, clears bypass, bound bits, group entries, queues
// the key ram (group, held flag) is not swept; a bind writes the entry before use
// top level: front classifier, queue, back executor, output queue
module key_group_last_input_priority
    import kglip_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int NUM_GROUPS = NUM_GROUPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    kglip_in_if.sink    i_in_word,
    kglip_out_if.source o_out_word
);
    localparam int QW = $bits(t_qent);
    localparam int RW = $bits(t_res);

    logic        q_push, q_full, q_pop, q_valid;
    t_qent       q_wdata;
    logic [QW-1:0] q_rdata;
    logic        res_push, res_full, res_valid;
    t_res        res_wdata;
    logic [RW-1:0] res_rdata;
    t_res        res_head;

    // front end
    kglip_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    // queue between front and back
    kglip_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    // back end
    kglip_back #(
        .NUM_KEYS   (NUM_KEYS),
        .NUM_GROUPS (NUM_GROUPS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (t_qent'(q_rdata)),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_wdata)
    );

    // output queue
    kglip_fifo #(
        .WIDTH (RW),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_wdata),
        .o_full  (res_full),
        .i_pop   (o_out_word.valid && o_out_word.ready),
        .o_valid (res_valid),
        .o_data  (res_rdata)
    );

    // output word
    assign res_head               = t_res'(res_rdata);
    assign o_out_word.valid       = res_valid;
    assign o_out_word.out_key     = res_head.key;
    assign o_out_word.out_pressed = res_head.pressed;
    assign o_out_word.kind        = res_head.kind;
    assign o_out_word.last        = res_head.last;
endmodule

// ----- tb/tb.sv -----
// self-checking testbench for the key group last-input-priority filter
module tb
    import kglip_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // word operations
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_BIND  = 1'b1;

    // cycles to let swallowed words leave the pipeline before a register write
    localparam int SETTLE_CYCLES = 12;

    // one input word
    typedef struct packed {
        logic       op;
        logic [7:0] key;
        logic       pressed;
        logic       inj;
        logic [3:0] gid;
    } t_word;

    // receiver stall patterns
    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } t_stall;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we;
    logic cfg_wdata;

    kglip_in_if  in_word ();
    kglip_out_if out_word ();

    key_group_last_input_priority uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_word   (in_word),
        .o_out_word  (out_word)
    );

    // filter state mirror
    logic       bypass_on;
    logic       key_bound [256];
    logic [3:0] key_group [256];
    logic       key_held  [256];
    logic [7:0] grp_active [16];
    logic [7:0] grp_prev   [16];
    logic [7:0] bound_keys [$];

    // reports still owed by the filter
    t_res expected_reports [$];
    t_res want;

    int error_count;
    int words_sent;
    int words_reporting;
    int reports_checked;
    int steal_count;
    int restore_count;
    int reject_count;
    int burst_left;

    t_stall stall_mode;
    int     stall_window;
    int     stall_left;

    // clock
    always #5 i_clk = ~i_clk;

    function automatic t_res report(input logic [7:0] k, input logic p, input logic [1:0] kd);
        t_res r;
        r.key     = k;
        r.pressed = p;
        r.kind    = kd;
        r.last    = 1'b0;
        return r;
    endfunction

    // compute the reports one accepted word causes and update the mirror
    task automatic filter_word(input t_word w);
        t_res       r [$];
        logic [7:0] k;
        logic [3:0] g;
        k = w.key;
        g = key_group[k];
        if (w.op == OP_BIND) begin
            if (key_bound[k]) begin
                r = {r, report(k, 1'b0, KIND_BIND_REJECT)};
                reject_count++;
            end else begin
                key_bound[k] = 1'b1;
                key_group[k] = w.gid;
                bound_keys = {bound_keys, k};
                r = {r, report(k, 1'b0, KIND_BIND_OK)};
            end
        end else if (bypass_on || w.inj || !key_bound[k]) begin
            r = {r, report(k, w.pressed, KIND_PASS)};
        end else if (w.pressed) begin
            // newest press wins, the old active key gets released
            if (!key_held[k]) begin
                key_held[k] = 1'b1;
                r = {r, report(k, 1'b1, KIND_SYNTH)};
                if (grp_active[g] == 8'd0 || grp_active[g] == k) begin
                    grp_active[g] = k;
                end else begin
                    grp_prev[g]   = grp_active[g];
                    grp_active[g] = k;
                    r = {r, report(grp_prev[g], 1'b0, KIND_SYNTH)};
                    steal_count++;
                end
            end
        end else begin
            // release of the recorded earlier key that is not held drops the record
            if (grp_prev[g] == k && !key_held[k])
                grp_prev[g] = 8'd0;
            if (key_held[k]) begin
                key_held[k] = 1'b0;
                if (grp_active[g] == k && grp_prev[g] != 8'd0) begin
                    r = {r, report(k, 1'b0, KIND_SYNTH)};
                    grp_active[g] = grp_prev[g];
                    grp_prev[g]   = 8'd0;
                    r = {r, report(grp_active[g], 1'b1, KIND_SYNTH)};
                    restore_count++;
                end else begin
                    grp_prev[g] = 8'd0;
                    if (grp_active[g] == k)
                        grp_active[g] = 8'd0;
                    r = {r, report(k, 1'b0, KIND_SYNTH)};
                end
            end
        end
        if (r.size() > 0) begin
            r[r.size() - 1].last = 1'b1;
            words_reporting++;
        end
        foreach (r[i])
            expected_reports = {expected_reports, r[i]};
    endtask

    // drive one word in bursts with random gaps, predict on acceptance
    task automatic send_word(input t_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_word.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_word.valid       <= 1'b1;
        in_word.operation   <= w.op;
        in_word.key_code    <= w.key;
        in_word.key_pressed <= w.pressed;
        in_word.injected    <= w.inj;
        in_word.group_id    <= w.gid;
        do @(posedge i_clk); while (!in_word.ready);
        burst_left--;
        words_sent++;
        filter_word(w);
    endtask

    task automatic send_event(input logic [7:0] k, input logic p, input logic inj);
        t_word w;
        w.op      = OP_EVENT;
        w.key     = k;
        w.pressed = p;
        w.inj     = inj;
        w.gid     = 4'($urandom_range(0, 15));
        send_word(w);
    endtask

    task automatic send_bind(input logic [7:0] k, input logic [3:0] g);
        t_word w;
        w.op      = OP_BIND;
        w.key     = k;
        w.pressed = 1'($urandom_range(0, 1));
        w.inj     = 1'($urandom_range(0, 1));
        w.gid     = g;
        send_word(w);
    endtask

    // hold off the sender until every owed report has come out
    task automatic wait_reports_done();
        in_word.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bypass(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        bypass_on = v;
    endtask

    // random word, mostly well-formed press/release pairs on bound keys
    function automatic t_word random_word();
        t_word      w;
        int         pick;
        logic [7:0] k;
        pick      = $urandom_range(0, 99);
        w.op      = OP_EVENT;
        w.key     = 8'($urandom_range(0, 255));
        w.pressed = 1'($urandom_range(0, 1));
        w.inj     = 1'b0;
        w.gid     = 4'($urandom_range(0, 15));
        if (pick < 5) begin
            w.op = OP_BIND;
            if (pick > 0)
                w.gid = 4'($urandom_range(0, 3));
        end else if (pick < 9) begin
            w.inj = 1'b1;
        end else if (pick >= 13) begin
            k     = bound_keys[$urandom_range(0, bound_keys.size() - 1)];
            w.key = k;
            w.pressed = ($urandom_range(0, 9) == 0) ? key_held[k] : !key_held[k];
        end
        return w;
    endfunction

    // check each accepted report and drive the receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && out_word.valid && out_word.ready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected word: key %0d pressed %0d kind %0d last %0d",
                       out_word.out_key, out_word.out_pressed, out_word.kind, out_word.last);
                error_count++;
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (out_word.out_key !== want.key) begin
                    $error("out_key: expected %0d, got %0d", want.key, out_word.out_key);
                    error_count++;
                end
                if (out_word.out_pressed !== want.pressed) begin
                    $error("out_pressed: expected %0d, got %0d",
                           want.pressed, out_word.out_pressed);
                    error_count++;
                end
                if (out_word.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, out_word.kind);
                    error_count++;
                end
                if (out_word.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_word.last);
                    error_count++;
                end
            end
        end
        if (stall_window == 0) begin
            stall_mode   = t_stall'($urandom_range(0, 3));
            stall_window = $urandom_range(20, 120);
        end
        stall_window--;
        case (stall_mode)
            STALL_NONE: begin
                out_word.ready <= 1'b1;
            end
            STALL_LIGHT: begin
                out_word.ready <= ($urandom_range(0, 3) != 0);
            end
            STALL_HEAVY: begin
                out_word.ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_word.ready <= 1'b0;
                end else begin
                    out_word.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // binds, duplicates and the extremes of key and group
    task automatic test_bind_rules();
        send_bind(8'd0, 4'd0);
        send_bind(8'd255, 4'd15);
        send_bind(8'h41, 4'd3);
        send_bind(8'h42, 4'd3);
        send_bind(8'h43, 4'd3);
        send_bind(8'h41, 4'd7);
    endtask

    // steal on press, restore on release, swallowed repeats
    task automatic test_group_priority();
        send_event(8'h41, 1'b1, 1'b0);
        send_event(8'h42, 1'b1, 1'b0);
        send_event(8'h42, 1'b1, 1'b0);
        send_event(8'h43, 1'b1, 1'b0);
        send_event(8'h43, 1'b0, 1'b0);
        send_event(8'h42, 1'b0, 1'b0);
        send_event(8'h41, 1'b0, 1'b0);
        send_event(8'h41, 1'b0, 1'b0);
        // key zero reads as an empty group entry
        send_event(8'd0, 1'b1, 1'b0);
        send_event(8'd255, 1'b1, 1'b0);
        send_event(8'd255, 1'b0, 1'b0);
        send_event(8'd0, 1'b0, 1'b0);
        send_event(8'd0, 1'b0, 1'b0);
    endtask

    // unbound and injected words go through untouched
    task automatic test_passthrough();
        send_event(8'h10, 1'b1, 1'b0);
        send_event(8'h41, 1'b1, 1'b1);
        send_event(8'h41, 1'b0, 1'b1);
    endtask

    // bypass passes key events, binds are still handled
    task automatic test_bypass();
        wait_reports_done();
        set_bypass(1'b1);
        send_event(8'h41, 1'b1, 1'b0);
        send_event(8'h41, 1'b0, 1'b0);
        send_bind(8'h50, 4'd9);
        send_bind(8'h50, 4'd2);
        wait_reports_done();
        set_bypass(1'b0);
    endtask

    // random traffic in phases, bypass toggled between phases
    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < 5; phase++) begin
            wait_reports_done();
            set_bypass(1'(phase % 2));
            target = words_reporting + ((phase % 2) ? 100 : 250);
            while (words_reporting < target)
                send_word(random_word());
        end
        wait_reports_done();
    endtask

    initial begin
        cfg_we               = 1'b0;
        cfg_wdata            = 1'b0;
        in_word.valid        = 1'b0;
        in_word.operation    = OP_EVENT;
        in_word.key_code     = 8'd0;
        in_word.key_pressed  = 1'b0;
        in_word.injected     = 1'b0;
        in_word.group_id     = 4'd0;
        out_word.ready       = 1'b0;
        bypass_on            = 1'b0;
        error_count          = 0;
        words_sent           = 0;
        words_reporting      = 0;
        reports_checked      = 0;
        steal_count          = 0;
        restore_count        = 0;
        reject_count         = 0;
        burst_left           = 0;
        stall_mode           = STALL_NONE;
        stall_window         = 0;
        stall_left           = 0;
        for (int i = 0; i < 256; i++) begin
            key_bound[i] = 1'b0;
            key_group[i] = 4'd0;
            key_held[i]  = 1'b0;
        end
        for (int i = 0; i < 16; i++) begin
            grp_active[i] = 8'd0;
            grp_prev[i]   = 8'd0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_bind_rules();
        test_group_priority();
        test_passthrough();
        test_bypass();
        test_random_traffic();

        if (expected_reports.size() != 0) begin
            $error("%0d expected words never arrived", expected_reports.size());
            error_count++;
        end
        $display("run: %0d input words, %0d result words checked, %0d binds rejected",
                 words_sent, reports_checked, reject_count);
        $display("run: %0d presses stole a group, %0d releases restored the earlier key",
                 steal_count, restore_count);
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

// ----- key_group_last_input_priority.f -----
rtl/kglip_pkg.sv
rtl/kglip_in_if.sv
rtl/kglip_out_if.sv
rtl/kglip_ram.sv
rtl/kglip_fifo.sv
rtl/kglip_front.sv
rtl/kglip_back.sv
rtl/key_group_last_input_priority.sv
tb/tb.sv
